[rtl/core/otms_pkg.sv]
// ----------------------------------------------------------------------------
// otms_pkg: shared types and constants for the orientation template scorer
// Payload structs, register indexes, field widths and the cell popcount.
// ----------------------------------------------------------------------------
package otms_pkg;

	localparam int TL_BIT_POS   = 7;
	localparam int CELL_W       = 8;
	localparam int BITS_W       = 16;
	localparam int TL_W         = 13;
	localparam int AREA_W       = 13;
	localparam int RATIO_W      = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int AREA_PROD_W  = RATIO_W + AREA_W;
	localparam int LIMIT_W      = RATIO_W + BITS_W;
	localparam int PC_W         = 4;

	localparam logic [CELL_W-1:0] TEXTURELESS_CODE = CELL_W'(1 << TL_BIT_POS);

	localparam logic [CFG_IDX_W-1:0] REG_TEMPLATE_AREA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TEXTURELESS = 2'd2;

	localparam logic [AREA_W-1:0]      AREA_RESET      = 13'd1;
	localparam logic [RATIO_W-1:0]     MIN_RATIO_RESET = 16'd55706;
	localparam logic [RATIO_W-1:0]     MAX_TL_RESET    = 16'd0;
	localparam logic [AREA_PROD_W-1:0] AREA_PROD_RESET = 29'd55706;

	localparam logic [CELL_W-1:0] MASK_PAIRS   = 8'h55;
	localparam logic [CELL_W-1:0] MASK_QUADS   = 8'h33;
	localparam logic [CELL_W-1:0] MASK_NIBBLES = 8'h0f;

	typedef struct packed {
		logic [CELL_W-1:0] query_cell;
		logic [CELL_W-1:0] template_cell;
		logic              last_cell;
	} in_t;

	typedef struct packed {
		logic              match;
		logic [BITS_W-1:0] bit_count;
		logic [TL_W-1:0]   textureless_count;
		logic              empty_window;
	} out_t;

	// window totals handed from the accumulator to the scorer
	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic [TL_W-1:0]   tl;
	} win_t;

	// thresholds handed from the register file to the scorer
	typedef struct packed {
		logic [AREA_PROD_W-1:0] area_prod;
		logic [RATIO_W-1:0]     max_tl;
	} thr_t;

	function automatic logic [PC_W-1:0] popcount8(input logic [CELL_W-1:0] v);
		logic [CELL_W-1:0] a;
		logic [CELL_W-1:0] b;
		logic [CELL_W-1:0] c;
		a = (v & MASK_PAIRS) + ((v >> 1) & MASK_PAIRS);
		b = (a & MASK_QUADS) + ((a >> 2) & MASK_QUADS);
		c = (b & MASK_NIBBLES) + ((b >> 4) & MASK_NIBBLES);
		return c[PC_W-1:0];
	endfunction

endpackage

[rtl/core/orientation_template_match_score.sv]
// ----------------------------------------------------------------------------
// orientation_template_match_score: window score against a stored template
// Streams cell pairs, accumulates matched bits and emits one score per window.
// ----------------------------------------------------------------------------
// The block takes one query/template cell pair per cycle, back to back, with
// no gaps needed between windows. Each pair is ANDed; the popcount of the AND
// adds to a saturating 16-bit bit count and an AND of exactly the textureless
// code adds to a saturating 13-bit textureless count. The pair flagged
// last_cell closes the window: one result word becomes valid once that pair
// has passed the input register, totals register, limit multiplier stage
// and result register, and the counters start the next window from zero.
// Match is set
// when bit_count*65536 > min_ratio_q16*template_area and
// textureless_count*65536 < max_textureless_q16*bit_count; an all-zero bit
// count sets empty_window and clears match. Throughput is set by the single
// accumulator adder: one cell per cycle. A result that waits at the output
// does not stop plain cells; up to three results can wait (result, scorer and
// totals registers), and only a last cell that finds all three full holds
// the input until room opens.
// Write configuration only while no window is in flight; the area product
// settles in the cycle after a write. Indexes beyond the three registers are
// ignored, and cfg_ready is always high.
// ----------------------------------------------------------------------------
module orientation_template_match_score (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  otms_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output otms_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [otms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [otms_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import otms_pkg::*;

	// thresholds from the register file
	thr_t thr;

	// closed-window totals between accumulator and scorer
	logic win_valid;
	logic win_ready;
	win_t win;

	// hold the registers and the registered area limit
	otms_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	// register each pair, accumulate, and drop totals on the last cell
	otms_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win)
	);

	// advance totals through the limit multiply and the ratio compares
	otms_score u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win),
		.thr       (thr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[rtl/core/otms_cfg_regs.sv]
// ----------------------------------------------------------------------------
// otms_cfg_regs: configuration registers
// Holds area and ratio thresholds and keeps the area limit product registered.
// ----------------------------------------------------------------------------
module otms_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [otms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [otms_pkg::CFG_DATA_W-1:0]   cfg_data,
	output otms_pkg::thr_t                    thr
);
	import otms_pkg::*;

	logic [AREA_W-1:0]      area_q;
	logic [RATIO_W-1:0]     min_ratio_q;
	logic [RATIO_W-1:0]     max_tl_q;
	logic [AREA_PROD_W-1:0] area_prod_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_q      <= AREA_RESET;
			min_ratio_q <= MIN_RATIO_RESET;
			max_tl_q    <= MAX_TL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEMPLATE_AREA:   area_q      <= cfg_data[AREA_W-1:0];
				REG_MIN_RATIO:       min_ratio_q <= cfg_data[RATIO_W-1:0];
				REG_MAX_TEXTURELESS: max_tl_q    <= cfg_data[RATIO_W-1:0];
				default:             ;
			endcase
		end
	end

	// follow the registers in the next cycle; settled long before a window ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_prod_q <= AREA_PROD_RESET;
		end else begin
			area_prod_q <= AREA_PROD_W'(min_ratio_q) * AREA_PROD_W'(area_q);
		end
	end

	assign thr.area_prod = area_prod_q;
	assign thr.max_tl    = max_tl_q;

endmodule

[rtl/core/otms_accum.sv]
// ----------------------------------------------------------------------------
// otms_accum: input register and window accumulators
// ANDs each cell pair, adds its popcount and counts textureless cells.
// ----------------------------------------------------------------------------
module otms_accum (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  otms_pkg::in_t   in_data,
	output logic            win_valid,
	input  logic            win_ready,
	output otms_pkg::win_t  win
);
	import otms_pkg::*;

	logic [CELL_W-1:0] cell_s1;
	logic              last_s1;
	logic              valid_s1;
	logic [BITS_W-1:0] bit_acc_q;
	logic [TL_W-1:0]   tl_acc_q;
	logic              win_valid_q;
	win_t              win_q;

	logic              drain;
	logic [PC_W-1:0]   pc;
	logic [BITS_W:0]   bit_sum;
	logic [BITS_W-1:0] bit_next;
	logic [TL_W-1:0]   tl_next;

	// a plain cell never waits; a last cell waits for the totals register
	assign drain    = valid_s1 && (!last_s1 || !win_valid_q || win_ready);
	assign in_ready = !valid_s1 || drain;

	always_comb begin
		pc       = popcount8(cell_s1);
		bit_sum  = {1'b0, bit_acc_q} + (BITS_W+1)'(pc);
		bit_next = bit_sum[BITS_W] ? {BITS_W{1'b1}} : bit_sum[BITS_W-1:0];
		if (cell_s1 == TEXTURELESS_CODE && tl_acc_q != {TL_W{1'b1}}) begin
			tl_next = tl_acc_q + TL_W'(1);
		end else begin
			tl_next = tl_acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cell_s1 <= in_data.query_cell & in_data.template_cell;
			last_s1 <= in_data.last_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_acc_q   <= '0;
			tl_acc_q    <= '0;
			win_valid_q <= 1'b0;
		end else begin
			if (drain) begin
				// clear after the last cell of a window
				bit_acc_q <= last_s1 ? '0 : bit_next;
				tl_acc_q  <= last_s1 ? '0 : tl_next;
			end
			if (drain && last_s1) begin
				win_valid_q <= 1'b1;
			end else if (win_ready) begin
				win_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain && last_s1) begin
			win_q.bits <= bit_next;
			win_q.tl   <= tl_next;
		end
	end

	assign win_valid = win_valid_q;
	assign win       = win_q;

endmodule

[rtl/core/otms_score.sv]
// ----------------------------------------------------------------------------
// otms_score: ratio tests and result register
// Multiplies the textureless limit, compares both ratios, holds the result.
// ----------------------------------------------------------------------------
module otms_score (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            win_valid,
	output logic            win_ready,
	input  otms_pkg::win_t  win,
	input  otms_pkg::thr_t  thr,
	output logic            out_valid,
	input  logic            out_ready,
	output otms_pkg::out_t  out_data
);
	import otms_pkg::*;

	logic              valid_s3;
	logic [BITS_W-1:0] bits_s3;
	logic [TL_W-1:0]   tl_s3;
	logic [LIMIT_W-1:0] limit_s3;
	logic              out_valid_q;
	out_t              out_q;

	logic              out_take;
	logic              move_s3;
	logic              empty;
	logic              ratio_ok;
	logic              tl_ok;

	assign out_take  = !out_valid_q || out_ready;
	assign move_s3   = valid_s3 && out_take;
	assign win_ready = !valid_s3 || move_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (win_ready) begin
			valid_s3 <= win_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (win_ready && win_valid) begin
			bits_s3  <= win.bits;
			tl_s3    <= win.tl;
			limit_s3 <= LIMIT_W'(thr.max_tl) * LIMIT_W'(win.bits);
		end
	end

	always_comb begin
		empty    = (bits_s3 == '0);
		ratio_ok = {bits_s3, 16'h0000} > LIMIT_W'(thr.area_prod);
		tl_ok    = LIMIT_W'({tl_s3, 16'h0000}) < limit_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s3) begin
			out_q.match             <= !empty && ratio_ok && tl_ok;
			out_q.bit_count         <= bits_s3;
			out_q.textureless_count <= tl_s3;
			out_q.empty_window      <= empty;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[test/tb_orientation_template_match_score.sv]
// ----------------------------------------------------------------------------
// tb_orientation_template_match_score: self-checking bench for the scorer
// Streams cell pairs through the valid/ready input with random gaps, stalls
// the result side at random, predicts every window score in the bench and
// checks each result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_orientation_template_match_score;
	timeunit 1ns;
	timeprecision 1ps;

	import otms_pkg::*;

	localparam int          MAX_IDLE        = 13;
	localparam int          RANDOM_ITEMS    = 1120;
	localparam int          SETTLE_CYC      = 8;
	localparam int          LONG_TL_CELLS   = 40;
	localparam int          LONG_FULL_CELLS = 120;
	localparam int unsigned BIT_SAT         = (1 << BITS_W) - 1;
	localparam int unsigned TL_SAT          = (1 << TL_W) - 1;
	// index past the register list; the block must drop writes to it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_t                  out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// bench copy of the registers and the window accumulators
	logic [AREA_W-1:0]  area_reg;
	logic [RATIO_W-1:0] min_ratio_reg;
	logic [RATIO_W-1:0] max_tl_reg;
	int unsigned        win_bits;
	int unsigned        win_tl;
	out_t               score_q[$];

	int unsigned mismatches;
	int unsigned tx_max_gap;
	bit          rx_quiet;
	int unsigned ready_wait;

	orientation_template_match_score u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Fold one accepted cell pair into the window; on the last pair queue
	// the score it must produce and clear the window.
	function automatic void score_cell(input in_t c);
		logic [CELL_W-1:0] both;
		int unsigned       ones;
		longint unsigned   bits_scaled;
		longint unsigned   area_limit;
		longint unsigned   tl_scaled;
		longint unsigned   tl_limit;
		out_t              r;
		both = c.query_cell & c.template_cell;
		ones = $countones(both);
		if (ones != 0) begin
			win_bits = (win_bits + ones > BIT_SAT) ? BIT_SAT : win_bits + ones;
			// exactly the textureless bit alone counts; saturate the count
			if (both == TEXTURELESS_CODE && win_tl < TL_SAT)
				win_tl++;
		end
		if (!c.last_cell)
			return;
		bits_scaled = longint'(win_bits) << 16;
		area_limit  = longint'(min_ratio_reg) * longint'(area_reg);
		tl_scaled   = longint'(win_tl) << 16;
		tl_limit    = longint'(max_tl_reg) * longint'(win_bits);
		r.bit_count         = win_bits[BITS_W-1:0];
		r.textureless_count = win_tl[TL_W-1:0];
		r.empty_window      = (win_bits == 0);
		r.match = !r.empty_window && (bits_scaled > area_limit) && (tl_scaled < tl_limit);
		score_q = {score_q, r};
		win_bits = 0;
		win_tl   = 0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_TEMPLATE_AREA:   area_reg      = data[AREA_W-1:0];
			REG_MIN_RATIO:       min_ratio_reg = data[RATIO_W-1:0];
			REG_MAX_TEXTURELESS: max_tl_reg    = data[RATIO_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic in_t cell_pair(input logic [CELL_W-1:0] q,
			input logic [CELL_W-1:0] t, input logic last);
		in_t c;
		c.query_cell    = q;
		c.template_cell = t;
		c.last_cell     = last;
		return c;
	endfunction

	// Mix of cell kinds so that matches, textureless hits and empty
	// windows all turn up often.
	function automatic in_t random_cell(input logic last);
		logic [CELL_W-1:0] r;
		r = CELL_W'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return cell_pair(r, CELL_W'($urandom), last);
			4, 5:       return cell_pair(r, r, last);
			// AND lands on the textureless code alone
			6:          return cell_pair(r | 8'h80, (~r & 8'h7f) | 8'h80, last);
			// AND is zero
			7:          return cell_pair(r, ~r, last);
			default:    return cell_pair(8'hff, r, last);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Send one cell pair: idle a random number of cycles, raise valid,
	// hold the word until taken, then predict from it.
	task automatic send_cell(input in_t c);
		int unsigned gap;
		gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do @(posedge clk); while (!in_ready);
		score_cell(c);
	endtask

	// Write one register; drop valid once the word is taken.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop input valid, wait for every queued score, then let the pipe
	// run empty so a register write cannot hit a window in flight.
	task automatic settle();
		in_valid <= 1'b0;
		while (score_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_thresholds(input logic [CFG_DATA_W-1:0] area,
			input logic [CFG_DATA_W-1:0] min_ratio, input logic [CFG_DATA_W-1:0] max_tl);
		settle();
		cfg_write(REG_TEMPLATE_AREA, area);
		cfg_write(REG_MIN_RATIO, min_ratio);
		cfg_write(REG_MAX_TEXTURELESS, max_tl);
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls and the checker
	// ------------------------------------------------------------------

	// After each taken word draw a stall; count it down with ready low.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			ready_wait = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
			out_ready <= (ready_wait == 0);
		end else if (ready_wait != 0) begin
			ready_wait--;
			out_ready <= (ready_wait == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (score_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected score word: match=%0d bits=%0d tl=%0d empty=%0d",
						out_data.match, out_data.bit_count,
						out_data.textureless_count, out_data.empty_window);
			end else begin
				want = score_q.pop_front();
				if (out_data.match !== want.match
						|| out_data.bit_count !== want.bit_count
						|| out_data.textureless_count !== want.textureless_count
						|| out_data.empty_window !== want.empty_window) begin
					mismatches++;
					if (mismatches <= 10)
						$display("score mismatch at %0t: exp match=%0d bits=%0d tl=%0d empty=%0d, got match=%0d bits=%0d tl=%0d empty=%0d",
							$realtime, want.match, want.bit_count,
							want.textureless_count, want.empty_window,
							out_data.match, out_data.bit_count,
							out_data.textureless_count, out_data.empty_window);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset thresholds: area 1, min ratio 0.85, max textureless 0. The
	// textureless test can never pass, so no window matches.
	task automatic test_reset_defaults();
		send_cell(cell_pair(8'hff, 8'hff, 1'b1));
		send_cell(cell_pair(8'h80, 8'h80, 1'b1));
		send_cell(cell_pair(8'h01, 8'h02, 1'b1));
	endtask

	// Extremes of both cell fields and the textureless corner cases.
	task automatic test_cell_extremes();
		set_thresholds(16'd1, 16'd0, 16'hffff);
		send_cell(cell_pair(8'h00, 8'h00, 1'b1));
		send_cell(cell_pair(8'hff, 8'h00, 1'b1));
		send_cell(cell_pair(8'h00, 8'hff, 1'b1));
		send_cell(cell_pair(8'h55, 8'haa, 1'b0));
		send_cell(cell_pair(8'hff, 8'hff, 1'b1));
		// only bit 7 survives the AND: textureless
		send_cell(cell_pair(8'h80, 8'hff, 1'b0));
		// bit 7 with another bit is not textureless
		send_cell(cell_pair(8'h81, 8'h81, 1'b0));
		send_cell(cell_pair(8'hc0, 8'h80, 1'b1));
		// all-textureless window fails the strict textureless test
		send_cell(cell_pair(8'h80, 8'h80, 1'b1));
	endtask

	// Zero area makes the ratio test pass for any nonzero bit count.
	task automatic test_zero_area();
		set_thresholds(16'd0, 16'hffff, 16'hffff);
		send_cell(cell_pair(8'h01, 8'h01, 1'b1));
		send_cell(cell_pair(8'h0f, 8'hf0, 1'b1));
	endtask

	// Register extremes, masking of the area write and a write to an
	// index past the list.
	task automatic test_register_extremes();
		int k;
		set_thresholds(16'hffff, 16'hffff, 16'hffff);
		cfg_write(REG_UNUSED, 16'h0000);
		for (k = 0; k < 8; k++)
			send_cell(cell_pair(8'hff, 8'hff, k == 7));
		set_thresholds(16'd4096, 16'd0, 16'd0);
		send_cell(cell_pair(8'h7f, 8'hff, 1'b1));
		settle();
		cfg_write(REG_MAX_TEXTURELESS, 16'hffff);
		cfg_write(REG_UNUSED, 16'h1234);
		send_cell(cell_pair(8'h7f, 8'hff, 1'b1));
	endtask

	// One long window streamed back to back: a run of textureless cells,
	// then full cells up to the last.
	task automatic test_long_window();
		int k;
		set_thresholds(16'd64, 16'd32768, 16'd4096);
		tx_max_gap = 0;
		for (k = 0; k < LONG_TL_CELLS; k++)
			send_cell(cell_pair(8'h80, 8'hc0, 1'b0));
		for (k = 0; k < LONG_FULL_CELLS; k++)
			send_cell(cell_pair(8'hff, 8'hff, k == LONG_FULL_CELLS - 1));
		tx_max_gap = MAX_IDLE;
	endtask

	// Random windows, mostly short, under several threshold settings.
	task automatic test_random_windows();
		int unsigned sent;
		int unsigned len;
		int unsigned k;
		int          phase;
		sent = 0;
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_thresholds(16'd1, 16'd0, 16'hffff);
				1: set_thresholds(16'd4096, 16'hffff, 16'd0);
				7: set_thresholds(16'd0, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
				default:
					set_thresholds(CFG_DATA_W'($urandom_range(1, 48)),
						CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
			endcase
			while (sent < (phase + 1) * RANDOM_ITEMS / 8) begin
				// some windows run with no idling on one side or both
				tx_max_gap = ($urandom_range(0, 4) == 0) ? 0 : MAX_IDLE;
				rx_quiet   = ($urandom_range(0, 4) == 0);
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 120)
					: $urandom_range(1, 12);
				for (k = 1; k <= len; k++)
					send_cell(random_cell(k == len));
				sent += len;
			end
		end
		tx_max_gap = MAX_IDLE;
		rx_quiet   = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_ready     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		area_reg      = AREA_RESET;
		min_ratio_reg = MIN_RATIO_RESET;
		max_tl_reg    = MAX_TL_RESET;
		win_bits      = 0;
		win_tl        = 0;
		mismatches    = 0;
		tx_max_gap    = MAX_IDLE;
		rx_quiet      = 1'b0;
		ready_wait    = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_cell_extremes();
		test_zero_area();
		test_register_extremes();
		test_long_window();
		test_random_windows();
		settle();

		if (mismatches == 0 && score_q.size() == 0) begin
			$display("** orientation_template_match_score: PASSED **");
		end else begin
			$display("** orientation_template_match_score: FAILED **");
		end
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#5_000_000;
		$display("** orientation_template_match_score: FAILED **");
		$finish;
	end

endmodule
